/* rtl/etqi_pkg.sv */
// ----------------------------------------------------------------------------
// etqi_pkg
// Shared types, constants and helpers for the escape-time iteration core.
// ----------------------------------------------------------------------------
package etqi_pkg;

  localparam int unsigned IdxW   = 20;   // pixel index width
  localparam int unsigned CountW = 16;   // iteration count width
  localparam int unsigned QW     = 64;   // Q32.32 word
  localparam int unsigned AccW   = 128;  // accumulator width
  localparam int unsigned StepW  = 5;    // sequencer step counter

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_JULIA_MODE  = 3'd0,
    CFG_ORIGIN_REAL = 3'd1,
    CFG_ORIGIN_IMAG = 3'd2,
    CFG_STEP_REAL   = 3'd3,
    CFG_STEP_IMAG   = 3'd4,
    CFG_CONST_REAL  = 3'd5,
    CFG_CONST_IMAG  = 3'd6,
    CFG_MAX_ITERS   = 3'd7
  } cfg_idx_t;

  localparam logic [CountW-1:0] MaxItersRst = 16'd256;

  // |z|^2 escape bound: 10^14 in Q64.64 (compared against the exact sum)
  localparam logic [AccW-1:0] EscThresh = {64'd100000000000000, 64'd0};

  // alignment of a partial product inside the accumulator
  typedef enum logic [2:0] {
    SH_0,
    SH_1,
    SH_32,
    SH_33,
    SH_64,
    SH_65
  } shift_t;

  // accumulate control, registered with the product and applied in the cycle after the multiply
  typedef struct packed {
    logic   en;
    shift_t sh;
    logic   to_re;
    logic   re_sub;
    logic   to_im;
    logic   im_sub;
    logic   to_sq;
  } acc_ctl_t;

  // multiplier operand selection: which magnitude register, which half
  typedef struct packed {
    logic x_mb;
    logic x_hi;
    logic y_mb;
    logic y_hi;
  } op_sel_t;

  function automatic logic [QW-1:0] mag64(input logic [QW-1:0] v);
    return v[QW-1] ? (~v + 64'd1) : v;
  endfunction

  // clamp a signed 128-bit value to the signed Q32.32 range
  function automatic logic [QW-1:0] sat_q(input logic [AccW-1:0] v);
    if ((&v[AccW-1:QW-1]) || !(|v[AccW-1:QW-1])) begin
      return v[QW-1:0];
    end
    return v[AccW-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

  function automatic logic [AccW-1:0] align_pp(input logic [QW-1:0] p, input shift_t sh);
    logic [AccW-1:0] w;
    w = {64'd0, p};
    case (sh)
      SH_0:    return w;
      SH_1:    return w << 1;
      SH_32:   return w << 32;
      SH_33:   return w << 33;
      SH_64:   return w << 64;
      SH_65:   return w << 65;
      default: return w;
    endcase
  endfunction

  // acc +/- term with a single carry-in adder
  function automatic logic [AccW-1:0] add_sub(input logic [AccW-1:0] acc,
                                               input logic [AccW-1:0] term,
                                               input logic            sub);
    return acc + (term ^ {AccW{sub}}) + {127'd0, sub};
  endfunction

endpackage

/* rtl/escape_time_quadratic_iteration_core.sv */
// ----------------------------------------------------------------------------
// escape_time_quadratic_iteration_core
// Per-pixel escape-time evaluator for z <- z*z + c in Q32.32 (Mandelbrot/Julia).
// ----------------------------------------------------------------------------
// Usage
//   Input: drive in_pixel_index and raise start; the transfer happens at the
//   clock edge where start is high and busy is low. busy then stays high until
//   the result has been produced.
//   Output: out_valid pulses for exactly one cycle with out_escape_count. The
//   receiver cannot stall; the result must be taken in that cycle.
//   Configuration: cfg_we/cfg_index/cfg_wdata write one register per edge. The
//   user must write only while busy is low; the block does not enforce this.
//   All registers reset to 0, max_iters to 256.
// Sequence
//   Index split (reciprocal multiply for the row, then the remainder for the
//   column), then point mapping. Each iteration issues 10 partial products to
//   one shared 32x32 multiplier, then drains the pipeline and updates z. An
//   escape is seen in the cross-product state of the iteration that tests it.
//   One pixel at a time; a new transfer is taken in the strobe cycle.
// Reset
//   Synchronous, active low; sequencer returns to idle, strobe cleared.
// ----------------------------------------------------------------------------
module escape_time_quadratic_iteration_core
  import etqi_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              start,
  output logic              busy,
  input  logic [IdxW-1:0]   in_pixel_index,
  // result channel
  output logic              out_valid,
  output logic [CountW-1:0] out_escape_count,
  // configuration
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [QW-1:0]     cfg_wdata
);

  // row = (index * DivRecip) >> DivSh, exact for every 20-bit index with
  // DivRecip = ceil(2^DivSh / IMAGE_WIDTH); column = index - row * width
  localparam int unsigned      DivSh     = IdxW + $clog2(IMAGE_WIDTH);
  localparam int unsigned      RecW      = IdxW + 2;
  localparam logic [63:0]      DivRecipW = ((64'd1 << DivSh) + 64'(IMAGE_WIDTH) - 64'd1) /
                                           64'(IMAGE_WIDTH);
  localparam logic [RecW-1:0]  DivRecip  = RecW'(DivRecipW);
  localparam logic [IdxW-1:0]  WidthK    = IdxW'(IMAGE_WIDTH);
  localparam logic [StepW-1:0] LastDiv   = StepW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,     // column/row split: quotient, then remainder
    S_MAP,     // step * column, step * row
    S_MAPFIN,  // saturate point, pick z and c
    S_SQ,      // |zr|^2 and |zi|^2
    S_CROSS,   // 2*zr*zi, escape test
    S_UPD      // saturate new z
  } state_t;

  // configuration registers
  logic              cfg_julia_mode_r;
  logic [QW-1:0]     cfg_origin_real_r, cfg_origin_imag_r;
  logic [QW-1:0]     cfg_step_real_r, cfg_step_imag_r;
  logic [QW-1:0]     cfg_const_real_r, cfg_const_imag_r;
  logic [CountW-1:0] cfg_max_iters_r;

  // control
  state_t            state_r, state_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CountW-1:0] out_count_r, out_count_nxt;

  // datapath
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [IdxW-1:0]   quot_r, quot_nxt;
  logic [QW-1:0]     ma_r, ma_nxt, mb_r, mb_nxt;
  logic              cross_neg_r, cross_neg_nxt;
  logic [QW-1:0]     cr_r, cr_nxt, ci_r, ci_nxt;
  logic [CountW-1:0] it_r, it_nxt;
  logic [AccW-1:0]   acc_re_r, acc_re_nxt, acc_im_r, acc_im_nxt, acc_sq_r, acc_sq_nxt;
  logic [QW-1:0]     pp_r;
  acc_ctl_t          pp_ctl_r, pp_ctl_nxt;

  // combinational helpers
  op_sel_t              op_sel;
  logic [QW-1:0]        x64, y64, prod;
  logic [31:0]          mul_x, mul_y;
  logic [AccW-1:0]      term;
  logic [IdxW+RecW-1:0] div_prod;
  logic [IdxW-1:0]      div_q, div_qw, div_rem;
  logic [QW-1:0]        map_re, map_im, upd_re, upd_im;
  logic [QW-1:0]        zs_re, zs_im, cs_re, cs_im;
  logic [CountW-1:0]    it_n;
  logic                 escaped;

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_escape_count = out_count_r;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_julia_mode_r  <= 1'b0;
      cfg_origin_real_r <= '0;
      cfg_origin_imag_r <= '0;
      cfg_step_real_r   <= '0;
      cfg_step_imag_r   <= '0;
      cfg_const_real_r  <= '0;
      cfg_const_imag_r  <= '0;
      cfg_max_iters_r   <= MaxItersRst;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_JULIA_MODE:  cfg_julia_mode_r  <= cfg_wdata[0];
        CFG_ORIGIN_REAL: cfg_origin_real_r <= cfg_wdata;
        CFG_ORIGIN_IMAG: cfg_origin_imag_r <= cfg_wdata;
        CFG_STEP_REAL:   cfg_step_real_r   <= cfg_wdata;
        CFG_STEP_IMAG:   cfg_step_imag_r   <= cfg_wdata;
        CFG_CONST_REAL:  cfg_const_real_r  <= cfg_wdata;
        CFG_CONST_IMAG:  cfg_const_imag_r  <= cfg_wdata;
        CFG_MAX_ITERS:   cfg_max_iters_r   <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Micro-op decode: operand halves for the multiplier and how its product
  // is folded into the accumulators in the following cycle.
  // --------------------------------------------------------------------------
  always_comb begin
    op_sel     = '0;
    pp_ctl_nxt = '0;
    case (state_r)
      S_MAP: begin
        // real: |step_real| * column into acc_re; imag: |step_imag| * row
        case (step_r)
          5'd0, 5'd1: begin
            pp_ctl_nxt.en     = 1'b1;
            pp_ctl_nxt.to_re  = 1'b1;
            pp_ctl_nxt.re_sub = cfg_step_real_r[QW-1];
            pp_ctl_nxt.sh     = (step_r == 5'd1) ? SH_32 : SH_0;
            op_sel.x_hi       = (step_r == 5'd1);
            op_sel.y_mb       = 1'b1;
          end
          5'd2, 5'd3: begin
            pp_ctl_nxt.en     = 1'b1;
            pp_ctl_nxt.to_im  = 1'b1;
            pp_ctl_nxt.im_sub = cfg_step_imag_r[QW-1];
            pp_ctl_nxt.sh     = (step_r == 5'd3) ? SH_32 : SH_0;
            op_sel.x_hi       = (step_r == 5'd3);
            op_sel.y_mb       = 1'b1;
          end
          default: ;
        endcase
      end
      S_SQ: begin
        // squares: lo*lo, 2*lo*hi, hi*hi; zr^2 adds into re, zi^2 subtracts
        if (step_r <= 5'd5) begin
          pp_ctl_nxt.en     = 1'b1;
          pp_ctl_nxt.to_sq  = 1'b1;
          pp_ctl_nxt.to_re  = 1'b1;
          pp_ctl_nxt.re_sub = (step_r >= 5'd3);
          op_sel.x_mb       = (step_r >= 5'd3);
          op_sel.y_mb       = (step_r >= 5'd3);
          case (step_r)
            5'd0, 5'd3: pp_ctl_nxt.sh = SH_0;
            5'd1, 5'd4: begin
              pp_ctl_nxt.sh = SH_33;
              op_sel.y_hi   = 1'b1;
            end
            default: begin
              pp_ctl_nxt.sh = SH_64;
              op_sel.x_hi   = 1'b1;
              op_sel.y_hi   = 1'b1;
            end
          endcase
        end
      end
      S_CROSS: begin
        // 2*|zr|*|zi|, sign applied in the accumulate
        if (step_r <= 5'd3) begin
          pp_ctl_nxt.en     = 1'b1;
          pp_ctl_nxt.to_im  = 1'b1;
          pp_ctl_nxt.im_sub = cross_neg_r;
          op_sel.y_mb       = 1'b1;
          case (step_r)
            5'd0: pp_ctl_nxt.sh = SH_1;
            5'd1: begin
              pp_ctl_nxt.sh = SH_33;
              op_sel.y_hi   = 1'b1;
            end
            5'd2: begin
              pp_ctl_nxt.sh = SH_33;
              op_sel.x_hi   = 1'b1;
            end
            default: begin
              pp_ctl_nxt.sh = SH_65;
              op_sel.x_hi   = 1'b1;
              op_sel.y_hi   = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // shared 32x32 multiplier, product registered before accumulation
  assign x64   = op_sel.x_mb ? mb_r : ma_r;
  assign y64   = op_sel.y_mb ? mb_r : ma_r;
  assign mul_x = op_sel.x_hi ? x64[QW-1:32] : x64[31:0];
  assign mul_y = op_sel.y_hi ? y64[QW-1:32] : y64[31:0];
  assign prod  = {32'd0, mul_x} * {32'd0, mul_y};
  assign term  = align_pp(pp_r, pp_ctl_r.sh);

  // column/row split by constant multiplies
  assign div_prod = {{RecW{1'b0}}, idx_r} * {{IdxW{1'b0}}, DivRecip};
  assign div_q    = IdxW'(div_prod >> DivSh);
  assign div_qw   = quot_r * WidthK;
  assign div_rem  = idx_r - div_qw;

  // saturated point and new z; accumulators hold value * 2^32 for z
  assign map_re = sat_q(acc_re_r);
  assign map_im = sat_q(acc_im_r);
  assign upd_re = sat_q({{32{acc_re_r[AccW-1]}}, acc_re_r[AccW-1:32]});
  assign upd_im = sat_q({{32{acc_im_r[AccW-1]}}, acc_im_r[AccW-1:32]});

  // z and c for the iteration that starts now
  always_comb begin
    if (state_r == S_UPD) begin
      zs_re = upd_re;
      zs_im = upd_im;
      cs_re = cr_r;
      cs_im = ci_r;
    end else if (cfg_julia_mode_r) begin
      zs_re = map_re;
      zs_im = map_im;
      cs_re = cfg_const_real_r;
      cs_im = cfg_const_imag_r;
    end else begin
      zs_re = '0;
      zs_im = '0;
      cs_re = map_re;
      cs_im = map_im;
    end
  end

  assign it_n    = (state_r == S_UPD) ? (it_r + 16'd1) : '0;
  assign escaped = (acc_sq_r > EscThresh);

  // --------------------------------------------------------------------------
  // Sequencer next-state and datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    idx_nxt       = idx_r;
    quot_nxt      = quot_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    cross_neg_nxt = cross_neg_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    it_nxt        = it_r;

    // delayed accumulate of the registered partial product
    acc_re_nxt = (pp_ctl_r.en && pp_ctl_r.to_re) ?
                 add_sub(acc_re_r, term, pp_ctl_r.re_sub) : acc_re_r;
    acc_im_nxt = (pp_ctl_r.en && pp_ctl_r.to_im) ?
                 add_sub(acc_im_r, term, pp_ctl_r.im_sub) : acc_im_r;
    acc_sq_nxt = (pp_ctl_r.en && pp_ctl_r.to_sq) ?
                 add_sub(acc_sq_r, term, 1'b0) : acc_sq_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_DIV;
          step_nxt   = '0;
          idx_nxt    = in_pixel_index;
          ma_nxt     = mag64(cfg_step_real_r);
          // origin preloaded, products are added on top
          acc_re_nxt = {{64{cfg_origin_real_r[QW-1]}}, cfg_origin_real_r};
          acc_im_nxt = {{64{cfg_origin_imag_r[QW-1]}}, cfg_origin_imag_r};
        end
      end
      S_DIV: begin
        step_nxt = step_r + 5'd1;
        if (step_r == LastDiv) begin
          state_nxt = S_MAP;
          step_nxt  = '0;
          mb_nxt    = QW'(div_rem);   // column
        end else begin
          quot_nxt  = div_q;          // row
        end
      end
      S_MAP: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd1) begin
          ma_nxt = mag64(cfg_step_imag_r);
          mb_nxt = QW'(quot_r);
        end
        if (step_r == 5'd4) begin
          state_nxt = S_MAPFIN;
        end
      end
      S_MAPFIN, S_UPD: begin
        it_nxt = it_n;
        if (it_n == cfg_max_iters_r) begin
          // ran out of iterations without escaping
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_count_nxt = '0;
        end else begin
          state_nxt     = S_SQ;
          step_nxt      = '0;
          ma_nxt        = mag64(zs_re);
          mb_nxt        = mag64(zs_im);
          cross_neg_nxt = zs_re[QW-1] ^ zs_im[QW-1];
          cr_nxt        = cs_re;
          ci_nxt        = cs_im;
          acc_sq_nxt    = '0;
          acc_re_nxt    = {{32{cs_re[QW-1]}}, cs_re, 32'd0};
          acc_im_nxt    = {{32{cs_im[QW-1]}}, cs_im, 32'd0};
        end
      end
      S_SQ: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd5) begin
          state_nxt = S_CROSS;
          step_nxt  = '0;
        end
      end
      S_CROSS: begin
        step_nxt = step_r + 5'd1;
        // last square product lands at the end of step 0
        if (step_r == 5'd1 && escaped) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_count_nxt = cfg_max_iters_r - it_r;
        end else if (step_r == 5'd4) begin
          state_nxt = S_UPD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      out_count_r <= '0;
      pp_ctl_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      out_count_r <= out_count_nxt;
      pp_ctl_r    <= pp_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    quot_r      <= quot_nxt;
    ma_r        <= ma_nxt;
    mb_r        <= mb_nxt;
    cross_neg_r <= cross_neg_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    it_r        <= it_nxt;
    acc_re_r    <= acc_re_nxt;
    acc_im_r    <= acc_im_nxt;
    acc_sq_r    <= acc_sq_nxt;
    pp_r        <= prod;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer did not start the sequencer");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (step_r <= LastDiv))
    else $error("division step counter overran");

endmodule
